FILE: src/gssu_pkg.sv
// shared types, constants and arithmetic helpers for the stencil update block
// no dependencies; imported by gray_scott_stencil_update_top
package gssu_pkg;

  // grid geometry
  localparam int GRID_WIDTH = 256;
  localparam int CNT_W      = $clog2(GRID_WIDTH);
  localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(GRID_WIDTH - 1);
  localparam logic [CNT_W-1:0] POS_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_ONE  = CNT_W'(1);

  // stream and register widths
  localparam int VAL_W  = 16;
  localparam int CELL_W = 2 * VAL_W;
  localparam int LINE_W = 2 * CELL_W;
  localparam int OUT_W  = 48;
  localparam int CFG_W  = 17;
  localparam int IDX_W  = 2;

  // register reset values
  localparam logic [16:0] DIFF_A_RST = 17'd65536;
  localparam logic [16:0] DIFF_B_RST = 17'd32768;
  localparam logic [15:0] FEED_RST   = 16'd3604;
  localparam logic [15:0] KILL_RST   = 16'd4063;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_DIFF_A = 2'd0,
    CFG_DIFF_B = 2'd1,
    CFG_FEED   = 2'd2,
    CFG_KILL   = 2'd3
  } cfg_idx_t;

  // laplacian divide: floor((2*S + 5) / 10) via biased reciprocal multiply
  localparam logic signed [24:0] U_OFFSET = 25'sd5242885;  // 10 * 2^19 + 5
  localparam logic [23:0]        RECIP    = 24'd13421773;  // ceil(2^27 / 10)
  localparam int                 RECIP_SH = 27;
  localparam logic [19:0]        LAP_BIAS = 20'h80000;     // 2^19

  // final rounding to q2.14
  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
  localparam logic signed [49:0] ROUND_HALF = 50'sd134217728;  // 2^27
  localparam int                 ROUND_SH   = 28;
  localparam logic signed [49:0] SAT_HI     = 50'sd32767;
  localparam logic signed [49:0] SAT_LO     = -50'sd32768;

  // position info that travels with a cell
  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       last;
  } pos_t;

  // biased weighted sum of one 3x3 neighborhood, always non-negative
  function automatic logic [22:0] stencil_u(
    input logic signed [15:0] nw, input logic signed [15:0] n,
    input logic signed [15:0] ne, input logic signed [15:0] w,
    input logic signed [15:0] c,  input logic signed [15:0] e,
    input logic signed [15:0] sw, input logic signed [15:0] s,
    input logic signed [15:0] se);
    logic signed [24:0] cs;
    logic signed [24:0] es;
    logic signed [24:0] t;
    cs = 25'(nw) + 25'(ne) + 25'(sw) + 25'(se);
    es = 25'(n) + 25'(w) + 25'(e) + 25'(s);
    t  = (es <<< 3) + (cs <<< 1) - (25'(c) <<< 5) - (25'(c) <<< 3) + U_OFFSET;
    return t[22:0];
  endfunction

  // round to nearest (ties up) at 14 fraction bits and saturate
  function automatic logic [15:0] round_sat(input logic signed [49:0] v);
    logic signed [49:0] t;
    logic [15:0]        r;
    t = (v + ROUND_HALF) >>> ROUND_SH;
    if (t > SAT_HI) begin
      r = 16'h7fff;
    end else if (t < SAT_LO) begin
      r = 16'h8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

FILE: src/gssu_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the line store of the stencil update block
module gssu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when both ports hit one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/gray_scott_stencil_update_top.sv
// reaction-diffusion stencil update, one grid cell per cycle while m_tready allows
// depends on gssu_pkg and gssu_ram
//
// Usage: cells of a square grid enter in raster order on the s_ channel, one
// transaction per cell (A in s_tdata[15:0], B in s_tdata[31:16], both q2.14);
// s_tuser marks the first cell of a pass and forces the position to row 0,
// column 0. When cell (r, c) with r >= 2 and c >= 2 arrives, the updated
// interior cell (r-1, c-1) leaves on the m_ channel; border cells produce no
// transaction. m_tlast flags the last interior cell of the pass.
// Throughput is one cell per cycle while m_tready holds no result back. Once the
// cell that completes its neighborhood is accepted, its result passes the line
// store read, the window shift, the arithmetic stages and the output register.
// Each stage holds its own valid bit, so bubbles close up and s_tready stays
// high while a result waits on m_tready, until the stages behind it fill.
// Reset clears the position, the window and all valid bits and loads the default
// rates; the line store keeps its contents, which reach results only after the
// current pass has written them. Rate registers are written on the cfg_ port,
// by the user only while no transaction is in flight; the block does not check.
module gray_scott_stencil_update_top (
  input  logic                        clk,
  input  logic                        rst,
  // slave stream: tdata = a_value, b_value; tuser = frame_start
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [gssu_pkg::CELL_W-1:0] s_tdata,
  input  logic                        s_tuser,
  // master stream: tdata = a_next, b_next, out_row, out_col; tlast = frame_last
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [gssu_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tlast,
  // register write port
  input  logic                        cfg_we,
  input  logic [gssu_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gssu_pkg::CFG_W-1:0]  cfg_data
);
  import gssu_pkg::*;

  // rate registers
  logic [16:0] diff_a;
  logic [16:0] diff_b;
  logic [15:0] feed;
  logic [15:0] kill;

  // position counters
  logic [CNT_W-1:0] col_cnt;
  logic [CNT_W-1:0] row_cnt;
  logic [CNT_W-1:0] col_use;
  logic [CNT_W-1:0] row_use;
  logic [CNT_W-1:0] col_cnt_next;
  logic [CNT_W-1:0] row_cnt_next;
  logic             emit_in;
  pos_t             pos_in;

  // stage ready chain
  logic rdy_o, rdy4, rdy3, rdy2, rdy1, rdy_b, rdy_a;
  logic accept;

  // line store read stage
  logic              a_v;
  logic              a_new;
  logic              a_byp;
  logic [LINE_W-1:0] a_bdata;
  logic [CELL_W-1:0] a_cur;
  logic [CNT_W-1:0]  a_col;
  logic              a_emit;
  pos_t              a_pos;
  logic [LINE_W-1:0] ram_rdata;
  logic [CELL_W-1:0] a_mid;
  logic [CELL_W-1:0] a_top;
  logic [LINE_W-1:0] ram_wdata;

  // window stage
  logic              b_v;
  logic              b_emit;
  pos_t              b_pos;
  logic [CELL_W-1:0] win [3][3];

  // arithmetic stages
  logic                     v1, v2, v3, v4;
  pos_t                     pos1, pos2, pos3, pos4;
  logic [22:0]              s1_ua, s1_ub;
  logic signed [15:0]       s1_a, s1_b;
  logic signed [31:0]       s1_bb;
  logic [19:0]              s2_qa, s2_qb;
  logic signed [15:0]       s2_a, s2_b;
  logic signed [47:0]       s2_abb;
  logic signed [33:0]       s2_fa, s2_kfb;
  logic signed [37:0]       s3_dla, s3_dlb;
  logic signed [15:0]       s3_a, s3_b;
  logic signed [47:0]       s3_abb;
  logic signed [33:0]       s3_fa, s3_kfb;
  logic signed [49:0]       s4_sa, s4_sb;

  // output register
  logic        o_v;
  logic [15:0] o_a, o_b;
  pos_t        o_pos;

  // combinational helpers for the arithmetic
  logic [46:0]        prod_a, prod_b;
  logic signed [16:0] one_m_a;
  logic signed [16:0] feed_s;
  logic signed [17:0] kf_s;
  logic signed [19:0] lap_a, lap_b;
  logic signed [17:0] da_s, db_s;

  // ready chain: a stage takes data when empty or when it drains
  assign rdy_o    = !o_v || m_tready;
  assign rdy4     = !v4 || rdy_o;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy_b    = !b_v || rdy1;
  assign rdy_a    = !a_v || rdy_b;
  assign s_tready = rdy_a;
  assign accept   = s_tvalid && rdy_a;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_a <= DIFF_A_RST;
      diff_b <= DIFF_B_RST;
      feed   <= FEED_RST;
      kill   <= KILL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIFF_A: diff_a <= cfg_data[16:0];
        CFG_DIFF_B: diff_b <= cfg_data[16:0];
        CFG_FEED:   feed   <= cfg_data[15:0];
        CFG_KILL:   kill   <= cfg_data[15:0];
        default:    feed   <= feed;
      endcase
    end
  end

  // position of the arriving cell and what it emits
  always_comb begin
    col_use = s_tuser ? '0 : col_cnt;
    row_use = s_tuser ? '0 : row_cnt;
    if (col_use == POS_LAST) begin
      col_cnt_next = '0;
      row_cnt_next = (row_use == POS_LAST) ? '0 : row_use + POS_ONE;
    end else begin
      col_cnt_next = col_use + POS_ONE;
      row_cnt_next = row_use;
    end
    emit_in     = (row_use >= POS_TWO) && (col_use >= POS_TWO);
    pos_in.row  = 8'(row_use - POS_ONE);
    pos_in.col  = 8'(col_use - POS_ONE);
    pos_in.last = (row_use == POS_LAST) && (col_use == POS_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // line store: [31:0] row above, [63:32] two rows above
  gssu_ram #(
    .WIDTH (LINE_W),
    .DEPTH (GRID_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (a_new),
    .waddr (a_col),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_use),
    .rdata (ram_rdata)
  );

  // forward the entry written in the same cycle as this read
  assign a_mid     = a_byp ? a_bdata[CELL_W-1:0] : ram_rdata[CELL_W-1:0];
  assign a_top     = a_byp ? a_bdata[LINE_W-1:CELL_W] : ram_rdata[LINE_W-1:CELL_W];
  assign ram_wdata = {a_mid, a_cur};

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      a_new <= 1'b0;
    end else begin
      a_new <= accept;
      if (rdy_a) begin
        a_v <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cur   <= s_tdata;
      a_col   <= col_use;
      a_emit  <= emit_in;
      a_pos   <= pos_in;
      a_byp   <= a_new && (a_col == col_use);
      a_bdata <= ram_wdata;
    end
  end

  // window stage: shift one column in per cell
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (rdy_b) begin
      b_v <= a_v;
      if (a_v) begin
        for (int i = 0; i < 3; i++) begin
          win[i][0] <= win[i][1];
          win[i][1] <= win[i][2];
        end
        win[0][2] <= a_top;
        win[1][2] <= a_mid;
        win[2][2] <= a_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && a_v) begin
      b_emit <= a_emit;
      b_pos  <= a_pos;
    end
  end

  // valid bits of the arithmetic stages, border cells drop out here
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (rdy1)  v1  <= b_v && b_emit;
      if (rdy2)  v2  <= v1;
      if (rdy3)  v3  <= v2;
      if (rdy4)  v4  <= v3;
      if (rdy_o) o_v <= v4;
    end
  end

  // stage 1: weighted neighborhood sums and b squared
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ua <= stencil_u(win[0][0][15:0], win[0][1][15:0], win[0][2][15:0],
                         win[1][0][15:0], win[1][1][15:0], win[1][2][15:0],
                         win[2][0][15:0], win[2][1][15:0], win[2][2][15:0]);
      s1_ub <= stencil_u(win[0][0][31:16], win[0][1][31:16], win[0][2][31:16],
                         win[1][0][31:16], win[1][1][31:16], win[1][2][31:16],
                         win[2][0][31:16], win[2][1][31:16], win[2][2][31:16]);
      s1_a  <= win[1][1][15:0];
      s1_b  <= win[1][1][31:16];
      s1_bb <= 32'($signed(win[1][1][31:16])) * 32'($signed(win[1][1][31:16]));
      pos1  <= b_pos;
    end
  end

  // stage 2: divide by ten, reaction products
  assign prod_a  = 47'(s1_ua) * 47'(RECIP);
  assign prod_b  = 47'(s1_ub) * 47'(RECIP);
  assign one_m_a = 17'(ONE_Q14) - 17'(s1_a);
  assign feed_s  = $signed({1'b0, feed});
  assign kf_s    = $signed({2'b00, kill} + {2'b00, feed});

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_qa  <= prod_a[RECIP_SH +: 20];
      s2_qb  <= prod_b[RECIP_SH +: 20];
      s2_abb <= 48'(s1_a) * 48'(s1_bb);
      s2_fa  <= 34'(feed_s) * 34'(one_m_a);
      s2_kfb <= 34'(kf_s) * 34'(s1_b);
      s2_a   <= s1_a;
      s2_b   <= s1_b;
      pos2   <= pos1;
    end
  end

  // stage 3: remove the bias, scale by the diffusion rates
  assign lap_a = $signed(s2_qa - LAP_BIAS);
  assign lap_b = $signed(s2_qb - LAP_BIAS);
  assign da_s  = $signed({1'b0, diff_a});
  assign db_s  = $signed({1'b0, diff_b});

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_dla <= 38'(da_s) * 38'(lap_a);
      s3_dlb <= 38'(db_s) * 38'(lap_b);
      s3_abb <= s2_abb;
      s3_fa  <= s2_fa;
      s3_kfb <= s2_kfb;
      s3_a   <= s2_a;
      s3_b   <= s2_b;
      pos3   <= pos2;
    end
  end

  // stage 4: exact sums with 42 fraction bits
  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_sa <= (50'(s3_a) <<< 28) + (50'(s3_dla) <<< 10) - 50'(s3_abb)
             + (50'(s3_fa) <<< 12);
      s4_sb <= (50'(s3_b) <<< 28) + (50'(s3_dlb) <<< 10) + 50'(s3_abb)
             - (50'(s3_kfb) <<< 12);
      pos4  <= pos3;
    end
  end

  // output register: round and saturate
  always_ff @(posedge clk) begin
    if (rdy_o) begin
      o_a   <= round_sat(s4_sa);
      o_b   <= round_sat(s4_sb);
      o_pos <= pos4;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {o_pos.col, o_pos.row, o_b, o_a};
  assign m_tlast  = o_pos.last;

endmodule
